/* hdl/circular_deque_unit_macros.svh */
// Assertion macros for the circular deque unit.
// Used by circular_deque_unit.sv; expects clk and rst_n in scope.
`ifndef CIRCULAR_DEQUE_UNIT_MACROS_SVH
`define CIRCULAR_DEQUE_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define CDQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("circular deque check failed");

// consequence holds in the same cycle as the antecedent
`define CDQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circular deque check failed");

// consequence holds in the cycle after the antecedent
`define CDQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular deque check failed");

`endif

/* hdl/cdq_pkg.sv */
// Shared types and constants of the circular deque unit.
// No dependencies; imported by cdq_ctrl, cdq_oreg and the top level.
package cdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CAP_RESET      = 16;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int CFG_W    = 5;
  localparam int OCOUNT_W = 5;

  // result tdata layout, lowest bit first
  localparam int OUT_ACC_BIT   = 0;
  localparam int OUT_POP_LSB   = 1;
  localparam int OUT_EMPTY_BIT = OUT_POP_LSB + VALUE_W;
  localparam int OUT_FULL_BIT  = OUT_EMPTY_BIT + 1;
  localparam int OUT_CNT_LSB   = OUT_FULL_BIT + 1;
  localparam int OUT_FRONT_LSB = OUT_CNT_LSB + OCOUNT_W;
  localparam int OUT_REAR_LSB  = OUT_FRONT_LSB + VALUE_W;
  localparam int OUT_TDATA_W   = OUT_REAR_LSB + VALUE_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef struct packed {
    logic accepted;
    logic is_empty;
    logic is_full;
  } cdq_status_t;

endpackage

/* hdl/cdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/cdq_ctrl.sv */
// Deque control: capacity, pointers, count, cached end values, request stage.
// Depends on cdq_pkg; drives the ring RAM and feeds cdq_oreg.
module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_valid,
  input  logic [CFG_W-1:0]                           cfg_data,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [OP_W-1:0]                            in_op,
  input  logic [VALUE_W-1:0]                         in_value,
  output logic                                       ram_we,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
  output logic [DATA_WIDTH-1:0]                      ram_wdata,
  output logic                                       ram_re,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_raddr,
  input  logic [DATA_WIDTH-1:0]                      ram_rdata,
  input  logic                                       oreg_free,
  output logic                                       s1_valid,
  output cdq_status_t                                s1_status,
  output logic [DATA_WIDTH-1:0]                      s1_popped,
  output logic [$clog2(DEPTH+1)-1:0]                 s1_count,
  output logic [DATA_WIDTH-1:0]                      cur_front,
  output logic [DATA_WIDTH-1:0]                      cur_rear,
  output logic [$clog2(DEPTH+1)-1:0]                 cnt,
  output logic [$clog2(DEPTH+1)-1:0]                 cap
);

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt, cnt_op, cap_r, cap_nxt;
  logic [IDX_W-1:0]      fidx_r, fidx_nxt, ridx_r, ridx_nxt, last;
  logic                  pend_f_r, pend_f_nxt, pend_r_r, pend_r_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt, rear_r, rear_nxt;
  logic [DATA_WIDTH-1:0] front_cur, rear_cur, val, popped;
  logic                  ok, in_fire, s1_take;
  logic                  s1_valid_r;
  cdq_status_t           s1_status_r;
  logic [DATA_WIDTH-1:0] s1_popped_r;
  logic [CNT_W-1:0]      s1_count_r;
  op_t                   op;

  assign op       = op_t'(in_op);
  assign val      = DATA_WIDTH'(in_value);
  assign s1_take  = s1_valid_r && oreg_free;
  assign in_ready = !s1_valid_r || oreg_free;
  assign in_fire  = in_valid && in_ready;
  assign last     = IDX_W'(cap_r - 1'b1);

  // an end value fetched by the last pop arrives from the RAM in the cycle after the pop
  assign front_cur = pend_f_r ? ram_rdata : front_r;
  assign rear_cur  = pend_r_r ? ram_rdata : rear_r;

  always_comb begin
    cnt_op     = cnt_r;
    fidx_nxt   = fidx_r;
    ridx_nxt   = ridx_r;
    front_nxt  = front_cur;
    rear_nxt   = rear_cur;
    pend_f_nxt = 1'b0;
    pend_r_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = val;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ok         = 1'b0;
    popped     = '0;
    if (in_fire) begin
      unique case (op) inside
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (cnt_r < cap_r) begin
            ok     = 1'b1;
            ram_we = 1'b1;
            cnt_op = cnt_r + 1'b1;
            if (cnt_r == '0) begin
              fidx_nxt  = '0;
              ridx_nxt  = '0;
              front_nxt = val;
              rear_nxt  = val;
            end else if (op == OP_PUSH_FRONT) begin
              fidx_nxt  = (fidx_r == '0) ? last : fidx_r - 1'b1;
              ram_waddr = fidx_nxt;
              front_nxt = val;
            end else begin
              ridx_nxt  = (ridx_r >= last) ? '0 : ridx_r + 1'b1;
              ram_waddr = ridx_nxt;
              rear_nxt  = val;
            end
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (cnt_r != '0) begin
            ok     = 1'b1;
            cnt_op = cnt_r - 1'b1;
            popped = (op == OP_POP_FRONT) ? front_cur : rear_cur;
            if (cnt_r == CNT_W'(1)) begin
              fidx_nxt = '0;
              ridx_nxt = '0;
            end else if (op == OP_POP_FRONT) begin
              fidx_nxt   = (fidx_r >= last) ? '0 : fidx_r + 1'b1;
              ram_re     = 1'b1;
              ram_raddr  = fidx_nxt;
              pend_f_nxt = 1'b1;
            end else begin
              ridx_nxt   = (ridx_r == '0) ? last : ridx_r - 1'b1;
              ram_re     = 1'b1;
              ram_raddr  = ridx_nxt;
              pend_r_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    cnt_nxt = cnt_op;
    cap_nxt = cap_r;
    // a capacity write empties the deque
    if (cfg_valid) begin
      if (cfg_data == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (int'(cfg_data) > DEPTH) begin
        cap_nxt = CNT_W'(DEPTH);
      end else begin
        cap_nxt = CNT_W'(cfg_data);
      end
      cnt_nxt    = '0;
      fidx_nxt   = '0;
      ridx_nxt   = '0;
      pend_f_nxt = 1'b0;
      pend_r_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      cap_r      <= CNT_W'(CAP_RST);
      fidx_r     <= '0;
      ridx_r     <= '0;
      pend_f_r   <= 1'b0;
      pend_r_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      cap_r    <= cap_nxt;
      fidx_r   <= fidx_nxt;
      ridx_r   <= ridx_nxt;
      pend_f_r <= pend_f_nxt;
      pend_r_r <= pend_r_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    rear_r  <= rear_nxt;
    if (in_fire) begin
      s1_status_r.accepted <= ok;
      s1_status_r.is_empty <= (cnt_op == '0);
      s1_status_r.is_full  <= (cnt_op == cap_r);
      s1_popped_r          <= popped;
      s1_count_r           <= cnt_op;
    end
  end

  assign s1_valid  = s1_valid_r;
  assign s1_status = s1_status_r;
  assign s1_popped = s1_popped_r;
  assign s1_count  = s1_count_r;
  assign cur_front = (cnt_r != '0) ? front_cur : '0;
  assign cur_rear  = (cnt_r != '0) ? rear_cur : '0;
  assign cnt       = cnt_r;
  assign cap       = cap_r;

endmodule

/* hdl/cdq_oreg.sv */
// Result register: packs one result per request and holds it under stall.
// Depends on cdq_pkg; fed by cdq_ctrl.
module cdq_oreg
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s1_valid,
  input  cdq_status_t                  s1_status,
  input  logic [DATA_WIDTH-1:0]        s1_popped,
  input  logic [$clog2(DEPTH+1)-1:0]   s1_count,
  input  logic [DATA_WIDTH-1:0]        cur_front,
  input  logic [DATA_WIDTH-1:0]        cur_rear,
  output logic                         oreg_free,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata
);

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign oreg_free = !out_valid_r || out_tready;

  // front and rear are read now: they reflect the state after the staged request
  always_comb begin
    out_data_nxt                                    = '0;
    out_data_nxt[OUT_ACC_BIT]                       = s1_status.accepted;
    out_data_nxt[OUT_POP_LSB +: VALUE_W]            = VALUE_W'(s1_popped);
    out_data_nxt[OUT_EMPTY_BIT]                     = s1_status.is_empty;
    out_data_nxt[OUT_FULL_BIT]                      = s1_status.is_full;
    out_data_nxt[OUT_CNT_LSB +: OCOUNT_W]           = OCOUNT_W'(s1_count);
    out_data_nxt[OUT_FRONT_LSB +: VALUE_W]          = VALUE_W'(cur_front);
    out_data_nxt[OUT_REAR_LSB +: VALUE_W]           = VALUE_W'(cur_rear);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (oreg_free) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (oreg_free && s1_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hdl/circular_deque_unit.sv */
// Circular deque unit, top level: a double-ended queue in a ring RAM.
// Depends on cdq_pkg, cdq_ram, cdq_ctrl, cdq_oreg and the macros header.
//
// Requests enter on in_* (stream slave): in_tuser carries the operation
// (push front, push rear, pop front, pop rear), in_tdata the push value.
// Each request gives exactly one result on out_* (stream master): accepted
// flag, popped value, empty, full, element count, front and rear values.
// A push on a full deque or a pop on an empty one is refused, not stalled.
// cfg_* writes the capacity (0 acts as 1, above DEPTH acts as DEPTH) and
// empties the deque; write it only while no request is in flight.
// A request passes the request stage, then the result register that drives
// out_tvalid. Throughput: one request per cycle while not stalled; a pop
// fetches the new end element from the single RAM read port, and that word
// is bypassed into the next request.
// Reset empties the deque and sets the capacity to 16 (DEPTH if smaller);
// the ring RAM is not cleared, entries are read only after being written.
// When out_tready is low the result register holds, one more request may
// wait in the request stage, and in_tready then drops.
`include "circular_deque_unit_macros.svh"

module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,   // [4:0] capacity
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [VALUE_W-1:0]     in_tdata,   // [31:0] push_value
  input  logic [OP_W-1:0]        in_tuser,   // [1:0] op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] accepted, [32:1] popped_value, [33] is_empty, [34] is_full,
  // [39:35] element_count, [71:40] front_value, [103:72] rear_value
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                  oreg_free, s1_valid;
  cdq_status_t           s1_status;
  logic [DATA_WIDTH-1:0] s1_popped, cur_front, cur_rear;
  logic [CNT_W-1:0]      s1_count, cnt, cap;
  logic                  push_on_full;

  assign cfg_ready = 1'b1;

  cdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_value  (in_tdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .oreg_free (oreg_free),
    .s1_valid  (s1_valid),
    .s1_status (s1_status),
    .s1_popped (s1_popped),
    .s1_count  (s1_count),
    .cur_front (cur_front),
    .cur_rear  (cur_rear),
    .cnt       (cnt),
    .cap       (cap)
  );

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cdq_oreg #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_status  (s1_status),
    .s1_popped  (s1_popped),
    .s1_count   (s1_count),
    .cur_front  (cur_front),
    .cur_rear   (cur_rear),
    .oreg_free  (oreg_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign push_on_full = in_tvalid && in_tready && !cfg_valid && (cnt == cap) &&
                        (in_tuser == OP_PUSH_FRONT || in_tuser == OP_PUSH_REAR);

  // count never runs past the configured capacity
  `CDQ_ASSERT_ALWAYS(a_cnt_in_cap, cnt <= cap)
  // a push into a full deque leaves the count alone
  `CDQ_ASSERT_NXT(a_full_push_held, push_on_full, cnt == $past(cnt))
  // a capacity write empties the deque
  `CDQ_ASSERT_NXT(a_cfg_empties, cfg_valid, cnt == '0)
  // capacity is at least one, so a result is never both empty and full
  `CDQ_ASSERT_IMP(a_out_status, out_tvalid, !(out_tdata[OUT_EMPTY_BIT] && out_tdata[OUT_FULL_BIT]))

endmodule
